[rtl/mnas_pkg.sv]
// shared types, codes and the dispatch match rule of the next-address sequencer
package mnas_pkg;

	localparam int PC_W      = 10;
	localparam int CFG_ADDR_W = 3;

	localparam logic REG_START_INDEX = 1'b0;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	localparam logic [2:0] KIND_NEXT     = 3'd0;
	localparam logic [2:0] KIND_SPIN     = 3'd1;
	localparam logic [2:0] KIND_JUMP     = 3'd2;
	localparam logic [2:0] KIND_JZ       = 3'd3;
	localparam logic [2:0] KIND_JNZ      = 3'd4;
	localparam logic [2:0] KIND_DISPATCH = 3'd5;

	localparam logic [6:0] OPC_AUIPC = 7'b0010111;
	localparam logic [6:0] OPC_LUI   = 7'b0110111;
	localparam logic [6:0] OPC_JAL   = 7'b1101111;
	localparam logic [6:0] OPC_OP    = 7'b0110011;
	localparam logic [2:0] F3_SLL    = 3'b001;
	localparam logic [2:0] F3_SR     = 3'b101;

	typedef struct packed {
		logic            opcode;
		logic [2:0]      branch_kind;
		logic [PC_W-1:0] jump_target;
		logic            dp_zero;
		logic            mem_busy;
		logic [31:0]     instruction;
		logic [5:0]      entry_slot;
		logic [6:0]      entry_opcode;
		logic [2:0]      entry_funct3;
		logic [6:0]      entry_funct7;
		logic [PC_W-1:0] entry_target;
	} item_t;

	typedef struct packed {
		logic [PC_W-1:0] next_index;
		logic            error;
		logic            decoded;
		logic [4:0]      rd_index;
		logic [4:0]      rs1_index;
		logic [4:0]      rs2_index;
	} result_t;

	typedef struct packed {
		logic [6:0]      opcode;
		logic [2:0]      funct3;
		logic [6:0]      funct7;
		logic [PC_W-1:0] target;
	} entry_t;

	typedef struct packed {
		logic            load;
		logic [PC_W-1:0] value;
	} pc_load_t;

	function automatic logic entry_hit(input entry_t e, input logic [31:0] insn);
		logic [6:0] op;
		logic [2:0] f3;
		logic [6:0] f7;
		logic       hit;
		op = insn[6:0];
		f3 = insn[14:12];
		f7 = insn[31:25];
		if (e.opcode != op) begin
			hit = 1'b0;
		end else if (op == OPC_AUIPC || op == OPC_LUI || op == OPC_JAL) begin
			hit = 1'b1;
		end else if (e.funct3 != f3) begin
			hit = 1'b0;
		end else if (op != OPC_OP && f3 != F3_SLL && f3 != F3_SR) begin
			hit = 1'b1;
		end else begin
			hit = (e.funct7 == f7);
		end
		return hit;
	endfunction

endpackage

[rtl/mnas_chan_if.sv]
// valid/ready channel carrying one beat of a typed payload
interface mnas_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[rtl/mnas_table.sv]
// dispatch table memory with one write port, one registered read port and valid bits
module mnas_table #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  we,
	input  logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] waddr,
	input  mnas_pkg::entry_t                      wdata,
	input  logic                                  re,
	input  logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] raddr,
	output mnas_pkg::entry_t                      rd_entry,
	output logic                                  rd_vld
);

	mnas_pkg::entry_t       mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;
	mnas_pkg::entry_t       entry_s1;
	logic                   vld_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			entry_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				vld_s1 <= valid_q[raddr];
			end
		end
	end

	assign rd_entry = entry_s1;
	assign rd_vld   = vld_s1;

endmodule

[rtl/mnas_ctrl.sv]
// sequencer control: item intake, table scan, micro-pc update and result register
module mnas_ctrl #(
	parameter int TABLE_DEPTH = 64,
	parameter int STORE_DEPTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	mnas_chan_if.sink           item,
	mnas_chan_if.source         result,
	input  mnas_pkg::pc_load_t  pc_load,
	output logic                tbl_we,
	output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] tbl_waddr,
	output mnas_pkg::entry_t    tbl_wdata,
	output logic                tbl_re,
	output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] tbl_raddr,
	input  mnas_pkg::entry_t    tbl_entry,
	input  logic                tbl_vld
);

	localparam int IDX_W = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = IDX_W + 1;
	localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_DEPTH);
	localparam logic [8:0] SLOT_LIM = 9'(TABLE_DEPTH);
	localparam logic [12:0] STORE_LIM = 13'(STORE_DEPTH);
	localparam bit NEED_MOD = STORE_DEPTH < 1024;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	function automatic logic [mnas_pkg::PC_W-1:0] fit_pc(input logic [mnas_pkg::PC_W-1:0] v);
		logic [17:0] r;
		r = 18'(v);
		if (NEED_MOD) begin
			for (int k = 5; k >= 0; k--) begin
				if (r >= 18'(STORE_DEPTH << k)) begin
					r = r - 18'(STORE_DEPTH << k);
				end
			end
		end
		return r[mnas_pkg::PC_W-1:0];
	endfunction

	logic [1:0]                 state_q;
	mnas_pkg::item_t            item_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       pend_s1;
	logic                       hit_q;
	logic [mnas_pkg::PC_W-1:0]  hit_tgt_q;
	logic [mnas_pkg::PC_W-1:0]  pc_q;
	logic                       res_valid_q;
	mnas_pkg::result_t          res_q;

	logic                       item_acc;
	logic                       out_free;
	logic                       retire;
	logic                       is_dispatch;
	logic                       scan_issue;
	logic                       scan_hit;
	logic                       scan_miss;
	logic                       slot_ok;
	logic [12:0]                pc_inc;
	logic [mnas_pkg::PC_W-1:0]  pc_adv;
	logic [mnas_pkg::PC_W-1:0]  tgt_fit;
	mnas_pkg::result_t          res_d;

	assign item.ready   = (state_q == ST_IDLE);
	assign item_acc     = item.valid && item.ready;
	assign is_dispatch  = (item.data.opcode == mnas_pkg::OP_STEP)
		&& (item.data.branch_kind == mnas_pkg::KIND_DISPATCH);
	assign out_free     = !res_valid_q || result.ready;
	assign retire       = ((state_q == ST_EXEC) || (state_q == ST_FIN)) && out_free;

	assign scan_issue   = (state_q == ST_SCAN) && (cnt_q < CNT_END);
	assign scan_hit     = (state_q == ST_SCAN) && pend_s1 && tbl_vld
		&& mnas_pkg::entry_hit(tbl_entry, item_q.instruction);
	assign scan_miss    = (state_q == ST_SCAN) && !pend_s1 && (cnt_q == CNT_END);

	assign tbl_re       = scan_issue;
	assign tbl_raddr    = cnt_q[IDX_W-1:0];

	assign slot_ok      = 9'(item_q.entry_slot) < SLOT_LIM;
	assign tbl_we       = (state_q == ST_EXEC) && out_free
		&& (item_q.opcode == mnas_pkg::OP_LOAD) && slot_ok;
	assign tbl_waddr    = IDX_W'(item_q.entry_slot);
	assign tbl_wdata    = '{opcode: item_q.entry_opcode, funct3: item_q.entry_funct3,
		funct7: item_q.entry_funct7, target: item_q.entry_target};

	assign pc_inc       = 13'(pc_q) + 13'd1;
	assign pc_adv       = (pc_inc == STORE_LIM) ? '0 : pc_inc[mnas_pkg::PC_W-1:0];
	assign tgt_fit      = fit_pc((state_q == ST_FIN) ? hit_tgt_q : item_q.jump_target);

	always_comb begin
		res_d            = '0;
		res_d.next_index = pc_q;
		if (item_q.opcode == mnas_pkg::OP_STEP) begin
			case (item_q.branch_kind)
				mnas_pkg::KIND_NEXT: res_d.next_index = pc_adv;
				mnas_pkg::KIND_SPIN: res_d.next_index = item_q.mem_busy ? pc_q : pc_adv;
				mnas_pkg::KIND_JUMP: res_d.next_index = tgt_fit;
				mnas_pkg::KIND_JZ:   res_d.next_index = item_q.dp_zero ? tgt_fit : pc_adv;
				mnas_pkg::KIND_JNZ:  res_d.next_index = item_q.dp_zero ? pc_adv : tgt_fit;
				mnas_pkg::KIND_DISPATCH: begin
					res_d.next_index = hit_q ? tgt_fit : pc_q;
					res_d.error      = !hit_q;
					res_d.decoded    = 1'b1;
					res_d.rd_index   = item_q.instruction[11:7];
					res_d.rs1_index  = item_q.instruction[19:15];
					res_d.rs2_index  = item_q.instruction[24:20];
				end
				default: res_d.error = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			pend_s1     <= 1'b0;
			hit_q       <= 1'b0;
			pc_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			pend_s1 <= scan_issue;
			if (scan_issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			res_valid_q <= retire || (res_valid_q && !result.ready);
			unique case (state_q) inside
				ST_IDLE: begin
					if (item_acc) begin
						cnt_q   <= '0;
						state_q <= is_dispatch ? ST_SCAN : ST_EXEC;
					end
				end
				ST_SCAN: begin
					if (scan_hit) begin
						hit_q   <= 1'b1;
						state_q <= ST_FIN;
					end else if (scan_miss) begin
						hit_q   <= 1'b0;
						state_q <= ST_FIN;
					end
				end
				ST_EXEC, ST_FIN: begin
					if (retire) begin
						pc_q    <= res_d.next_index;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (pc_load.load) begin
				pc_q <= fit_pc(pc_load.value);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			item_q <= item.data;
		end
		if (scan_hit) begin
			hit_tgt_q <= tbl_entry.target;
		end
		if (retire) begin
			res_q <= res_d;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule

[rtl/microcode_next_address_sequencer.sv]
// next-address sequencer top level: config register port, control and dispatch table
// load and non-dispatch step items pass through the execute state into the result register
// dispatch steps read the table memory one entry per cycle, lowest slot first, stopping at
// the first match; the finish state then registers the result, marked as an error on a miss
// one item in flight; the next item is accepted the cycle after a result is registered,
// even while that result waits on the output
// reset: micro-pc and start index go to 0 and all table entries read as empty
module microcode_next_address_sequencer #(
	parameter int TABLE_DEPTH = 64,
	parameter int STORE_DEPTH = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mnas_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	mnas_chan_if.sink                       item,
	mnas_chan_if.source                     result
);

	localparam int IDX_W = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;

	logic [mnas_pkg::PC_W-1:0] start_q;
	logic                      start_wr;
	mnas_pkg::pc_load_t        pc_load;
	logic                      tbl_we;
	logic [IDX_W-1:0]          tbl_waddr;
	mnas_pkg::entry_t          tbl_wdata;
	logic                      tbl_re;
	logic [IDX_W-1:0]          tbl_raddr;
	mnas_pkg::entry_t          tbl_entry;
	logic                      tbl_vld;

	assign pready   = 1'b1;
	assign start_wr = psel && penable && pwrite && pready
		&& (paddr[2] == mnas_pkg::REG_START_INDEX);
	assign prdata   = (paddr[2] == mnas_pkg::REG_START_INDEX) ? 32'(start_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (start_wr) begin
			start_q <= pwdata[mnas_pkg::PC_W-1:0];
		end
	end

	assign pc_load = '{load: start_wr, value: pwdata[mnas_pkg::PC_W-1:0]};

	mnas_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.STORE_DEPTH(STORE_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.result    (result),
		.pc_load   (pc_load),
		.tbl_we    (tbl_we),
		.tbl_waddr (tbl_waddr),
		.tbl_wdata (tbl_wdata),
		.tbl_re    (tbl_re),
		.tbl_raddr (tbl_raddr),
		.tbl_entry (tbl_entry),
		.tbl_vld   (tbl_vld)
	);

	mnas_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (tbl_we),
		.waddr    (tbl_waddr),
		.wdata    (tbl_wdata),
		.re       (tbl_re),
		.raddr    (tbl_raddr),
		.rd_entry (tbl_entry),
		.rd_vld   (tbl_vld)
	);

endmodule

[rtl/mnas_checker.sv]
// port-level checks of the next-address sequencer and their binding
module mnas_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mnas_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	input  logic [31:0]                     prdata,
	input  logic                            pready,
	mnas_chan_if.sink                       item,
	mnas_chan_if.source                     result
);

	logic start_wr;
	logic start_rd;

	assign start_wr = psel && penable && pwrite && pready
		&& (paddr[2] == mnas_pkg::REG_START_INDEX);
	assign start_rd = psel && !pwrite && (paddr[2] == mnas_pkg::REG_START_INDEX);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid && $stable(result.data))
		else $error("result beat changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("item accepted while another is in flight");

	a_plain_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.data.decoded |->
			result.data.rd_index == 5'd0 && result.data.rs1_index == 5'd0
			&& result.data.rs2_index == 5'd0)
		else $error("register fields set on a beat without decode");

	a_start_readback: assert property (@(posedge clk) disable iff (!arst_n)
		start_wr ##1 start_rd |-> prdata[mnas_pkg::PC_W-1:0] == $past(pwdata[mnas_pkg::PC_W-1:0]))
		else $error("start index readback mismatch");

endmodule

bind microcode_next_address_sequencer mnas_checker u_mnas_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.psel    (psel),
	.penable (penable),
	.pwrite  (pwrite),
	.paddr   (paddr),
	.pwdata  (pwdata),
	.prdata  (prdata),
	.pready  (pready),
	.item    (item),
	.result  (result)
);

[tb/tb.sv]
// testbench for the microcode next-address sequencer: directed table, random loads and steps, self-checking
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PC_BITS = mnas_pkg::PC_W;
	localparam int ADDR_BITS = mnas_pkg::CFG_ADDR_W;
	localparam int SLOTS = 64;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 200;
	localparam int SETTLE_CYCLES = 80;
	localparam int STUCK_LIMIT = 2000;

	localparam logic [ADDR_BITS-1:0] ADDR_START = ADDR_BITS'(4 * mnas_pkg::REG_START_INDEX);
	// no register decodes here
	localparam logic [ADDR_BITS-1:0] ADDR_SPARE = ADDR_BITS'(4);

	localparam logic [2:0] KIND_BAD_LO = 3'd6;
	localparam logic [2:0] KIND_BAD_HI = 3'd7;

	localparam logic [6:0] OPC_IMM    = 7'b0010011;
	localparam logic [6:0] OPC_MEM_LD = 7'b0000011;
	localparam logic [6:0] OPC_MEM_ST = 7'b0100011;
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;
	localparam logic [6:0] F7_ALT     = 7'b0100000;

	typedef struct {
		mnas_pkg::item_t   stim;
		bit                typed;
		mnas_pkg::result_t want;
	} drow_t;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	mnas_chan_if #(.T(mnas_pkg::item_t))   item_bus();
	mnas_chan_if #(.T(mnas_pkg::result_t)) result_bus();

	microcode_next_address_sequencer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item(item_bus),
		.result(result_bus)
	);

	logic [PC_BITS-1:0] pc_model;
	logic [PC_BITS-1:0] start_model;
	mnas_pkg::entry_t   entry_store [SLOTS];
	bit                 entry_live [SLOTS];
	mnas_pkg::result_t  next_addr_q [$];
	drow_t              script [$];

	bit calm;
	int stall_left;
	int stuck_cycles;
	int mismatches;
	int items_sent;
	int beats_checked;
	int loads_seen;
	int dispatch_hits;
	int dispatch_misses;
	int bad_kinds;
	int settings_used;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic bit entry_fits(input mnas_pkg::entry_t e, input logic [31:0] insn);
		bit loose;
		bit wide;
		loose = (insn[6:0] == mnas_pkg::OPC_AUIPC) || (insn[6:0] == mnas_pkg::OPC_LUI)
			|| (insn[6:0] == mnas_pkg::OPC_JAL);
		wide = (insn[6:0] == mnas_pkg::OPC_OP) || (insn[14:12] == mnas_pkg::F3_SLL)
			|| (insn[14:12] == mnas_pkg::F3_SR);
		return (e.opcode == insn[6:0]) &&
			(loose || ((e.funct3 == insn[14:12]) && (!wide || e.funct7 == insn[31:25])));
	endfunction

	function automatic mnas_pkg::result_t next_address(input mnas_pkg::item_t it);
		mnas_pkg::result_t r;
		bit hit;
		r = '0;
		if (it.opcode == mnas_pkg::OP_LOAD) begin
			entry_store[it.entry_slot] = '{opcode: it.entry_opcode, funct3: it.entry_funct3,
				funct7: it.entry_funct7, target: it.entry_target};
			entry_live[it.entry_slot] = 1'b1;
			loads_seen++;
		end else begin
			case (it.branch_kind)
				mnas_pkg::KIND_NEXT: pc_model = pc_model + PC_BITS'(1);
				mnas_pkg::KIND_SPIN: if (!it.mem_busy) pc_model = pc_model + PC_BITS'(1);
				mnas_pkg::KIND_JUMP: pc_model = it.jump_target;
				mnas_pkg::KIND_JZ:
					pc_model = it.dp_zero ? it.jump_target : pc_model + PC_BITS'(1);
				mnas_pkg::KIND_JNZ:
					pc_model = it.dp_zero ? pc_model + PC_BITS'(1) : it.jump_target;
				mnas_pkg::KIND_DISPATCH: begin
					r.decoded = 1'b1;
					r.rd_index = it.instruction[11:7];
					r.rs1_index = it.instruction[19:15];
					r.rs2_index = it.instruction[24:20];
					hit = 1'b0;
					for (int s = 0; s < SLOTS && !hit; s++) begin
						if (entry_live[s] && entry_fits(entry_store[s], it.instruction)) begin
							pc_model = entry_store[s].target;
							hit = 1'b1;
						end
					end
					r.error = !hit;
					if (hit) dispatch_hits++;
					else dispatch_misses++;
				end
				default: begin
					r.error = 1'b1;
					bad_kinds++;
				end
			endcase
		end
		r.next_index = pc_model;
		return r;
	endfunction

	function automatic mnas_pkg::item_t step_item(input logic [2:0] kind,
		input logic [PC_BITS-1:0] target, input logic zero, input logic busy,
		input logic [31:0] insn);
		mnas_pkg::item_t it;
		it = '0;
		it.opcode = mnas_pkg::OP_STEP;
		it.branch_kind = kind;
		it.jump_target = target;
		it.dp_zero = zero;
		it.mem_busy = busy;
		it.instruction = insn;
		return it;
	endfunction

	function automatic mnas_pkg::item_t load_item(input logic [5:0] slot, input logic [6:0] op,
		input logic [2:0] f3, input logic [6:0] f7, input logic [PC_BITS-1:0] target);
		mnas_pkg::item_t it;
		it = '0;
		it.opcode = mnas_pkg::OP_LOAD;
		it.entry_slot = slot;
		it.entry_opcode = op;
		it.entry_funct3 = f3;
		it.entry_funct7 = f7;
		it.entry_target = target;
		return it;
	endfunction

	function automatic logic [31:0] rv_word(input logic [6:0] f7, input logic [4:0] rs2,
		input logic [4:0] rs1, input logic [2:0] f3, input logic [4:0] rd, input logic [6:0] op);
		return {f7, rs2, rs1, f3, rd, op};
	endfunction

	function automatic mnas_pkg::result_t plain(input logic [PC_BITS-1:0] pc, input logic err);
		mnas_pkg::result_t r;
		r = '0;
		r.next_index = pc;
		r.error = err;
		return r;
	endfunction

	function automatic logic [6:0] hot_opcode();
		case ($urandom_range(0, 7))
			0: return mnas_pkg::OPC_AUIPC;
			1: return mnas_pkg::OPC_LUI;
			2: return mnas_pkg::OPC_JAL;
			3: return mnas_pkg::OPC_OP;
			4: return OPC_IMM;
			5: return OPC_MEM_LD;
			6: return OPC_MEM_ST;
			default: return OPC_BRANCH;
		endcase
	endfunction

	function automatic logic [31:0] dispatch_word();
		int filled [$];
		int s;
		int k;
		logic [31:0] w;
		w = $urandom();
		for (s = 0; s < SLOTS; s++) if (entry_live[s]) filled.push_back(s);
		if (filled.size() != 0 && $urandom_range(0, 3) != 0) begin
			s = filled[$urandom_range(0, filled.size() - 1)];
			w[6:0] = entry_store[s].opcode;
			w[14:12] = entry_store[s].funct3;
			w[31:25] = entry_store[s].funct7;
			// near miss on funct3 or funct7
			if ($urandom_range(0, 5) == 0) begin
				k = $urandom_range(0, 9);
				k = (k < 3) ? 12 + k : 22 + k;
				w[k] = ~w[k];
			end
		end
		return w;
	endfunction

	function automatic mnas_pkg::item_t random_item();
		mnas_pkg::item_t it;
		int roll;
		roll = $urandom_range(0, 99);
		it.opcode = (roll < 25) ? mnas_pkg::OP_LOAD : mnas_pkg::OP_STEP;
		roll = $urandom_range(0, 99);
		if (roll < 40) it.branch_kind = mnas_pkg::KIND_DISPATCH;
		else if (roll < 48) it.branch_kind = $urandom_range(0, 1) ? KIND_BAD_LO : KIND_BAD_HI;
		else it.branch_kind = 3'($urandom_range(mnas_pkg::KIND_NEXT, mnas_pkg::KIND_JNZ));
		it.jump_target = PC_BITS'($urandom());
		it.dp_zero = 1'($urandom());
		it.mem_busy = 1'($urandom());
		it.instruction = (it.opcode == mnas_pkg::OP_STEP
			&& it.branch_kind == mnas_pkg::KIND_DISPATCH) ? dispatch_word() : $urandom();
		it.entry_slot = 6'($urandom());
		it.entry_opcode = ($urandom_range(0, 9) < 7) ? hot_opcode() : 7'($urandom());
		it.entry_funct3 = 3'($urandom());
		if ($urandom_range(0, 1)) it.entry_funct7 = $urandom_range(0, 1) ? F7_ALT : 7'd0;
		else it.entry_funct7 = 7'($urandom());
		it.entry_target = PC_BITS'($urandom());
		return it;
	endfunction

	task automatic add_row(input mnas_pkg::item_t it, input bit typed,
		input mnas_pkg::result_t want);
		script.push_back('{stim: it, typed: typed, want: want});
	endtask

	task automatic build_directed();
		add_row(step_item(mnas_pkg::KIND_NEXT, 10'd0, 1'b0, 1'b0, 32'd0), 1'b1,
			plain(10'd1, 1'b0));
		add_row(step_item(mnas_pkg::KIND_SPIN, 10'd0, 1'b0, 1'b1, 32'd0), 1'b1,
			plain(10'd1, 1'b0));
		add_row(step_item(mnas_pkg::KIND_SPIN, 10'd0, 1'b0, 1'b0, 32'd0), 1'b1,
			plain(10'd2, 1'b0));
		add_row(step_item(mnas_pkg::KIND_JUMP, 10'd1023, 1'b0, 1'b0, 32'd0), 1'b1,
			plain(10'd1023, 1'b0));
		add_row(step_item(mnas_pkg::KIND_NEXT, 10'd0, 1'b0, 1'b0, 32'd0), 1'b1,
			plain(10'd0, 1'b0));
		add_row(step_item(mnas_pkg::KIND_JZ, 10'd512, 1'b1, 1'b0, 32'd0), 1'b1,
			plain(10'd512, 1'b0));
		add_row(step_item(mnas_pkg::KIND_JZ, 10'd512, 1'b0, 1'b0, 32'd0), 1'b1,
			plain(10'd513, 1'b0));
		add_row(step_item(mnas_pkg::KIND_JNZ, 10'd0, 1'b0, 1'b0, 32'd0), 1'b1,
			plain(10'd0, 1'b0));
		add_row(step_item(mnas_pkg::KIND_JNZ, 10'd1023, 1'b1, 1'b0, 32'd0), 1'b1,
			plain(10'd1, 1'b0));
		add_row(step_item(KIND_BAD_LO, 10'd5, 1'b0, 1'b0, 32'd0), 1'b1, plain(10'd1, 1'b1));
		add_row(step_item(KIND_BAD_HI, 10'd5, 1'b1, 1'b1, 32'd0), 1'b1, plain(10'd1, 1'b1));
		// empty table: decode still reported, micro-pc holds
		add_row(step_item(mnas_pkg::KIND_DISPATCH, 10'd0, 1'b0, 1'b0, 32'hFFFF_FFFF), 1'b1,
			'{next_index: 10'd1, error: 1'b1, decoded: 1'b1,
			rd_index: 5'd31, rs1_index: 5'd31, rs2_index: 5'd31});
		add_row(load_item(6'd0, mnas_pkg::OPC_OP, 3'd0, F7_ALT, 10'd100), 1'b1,
			plain(10'd1, 1'b0));
		add_row(load_item(6'd63, 7'h7F, 3'd7, 7'h7F, 10'd1023), 1'b0, '0);
		add_row(load_item(6'd62, mnas_pkg::OPC_OP, 3'd0, 7'd0, 10'd200), 1'b0, '0);
		add_row(load_item(6'd5, mnas_pkg::OPC_LUI, 3'd7, 7'h7F, 10'd300), 1'b0, '0);
		add_row(load_item(6'd10, OPC_IMM, 3'd0, 7'h55, 10'd400), 1'b0, '0);
		add_row(load_item(6'd11, OPC_IMM, mnas_pkg::F3_SLL, 7'd0, 10'd410), 1'b0, '0);
		add_row(step_item(mnas_pkg::KIND_DISPATCH, 10'd0, 1'b0, 1'b0,
			rv_word(F7_ALT, 5'd7, 5'd6, 3'd0, 5'd5, mnas_pkg::OPC_OP)), 1'b0, '0);
		add_row(step_item(mnas_pkg::KIND_DISPATCH, 10'd0, 1'b0, 1'b0,
			rv_word(7'd0, 5'd31, 5'd0, 3'd0, 5'd31, mnas_pkg::OPC_OP)), 1'b0, '0);
		add_row(step_item(mnas_pkg::KIND_DISPATCH, 10'd0, 1'b0, 1'b0,
			{20'hFFFFF, 5'd0, mnas_pkg::OPC_LUI}), 1'b0, '0);
		add_row(step_item(mnas_pkg::KIND_DISPATCH, 10'd0, 1'b0, 1'b0,
			rv_word(7'd1, 5'd3, 5'd2, mnas_pkg::F3_SLL, 5'd1, OPC_IMM)), 1'b0, '0);
		add_row(step_item(mnas_pkg::KIND_DISPATCH, 10'd0, 1'b0, 1'b0, 32'hFFFF_FFFF), 1'b0, '0);
		add_row(step_item(mnas_pkg::KIND_NEXT, 10'd0, 1'b1, 1'b1, 32'd0), 1'b0, '0);
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic send_item(input mnas_pkg::item_t it, input bit typed,
		input mnas_pkg::result_t want);
		mnas_pkg::result_t guess;
		item_bus.valid <= 1'b1;
		item_bus.data <= it;
		do @(posedge clk); while (!item_bus.ready);
		guess = next_address(it);
		next_addr_q.push_back(typed ? want : guess);
		items_sent++;
	endtask

	task automatic maybe_gap();
		if (!calm && $urandom_range(0, 5) == 0) begin
			item_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic drain();
		item_bus.valid <= 1'b0;
		while (next_addr_q.size() != 0) @(posedge clk);
	endtask

	task automatic apb_write(input logic [ADDR_BITS-1:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_check_start();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_START;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		compare_field("start_index readback", 32'(start_model), 32'(prdata[PC_BITS-1:0]));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_start(input logic [PC_BITS-1:0] value, input bit noisy);
		logic [31:0] word;
		word = noisy ? $urandom() : 32'd0;
		word[PC_BITS-1:0] = value;
		apb_write(ADDR_START, word);
		start_model = value;
		pc_model = value;
		settings_used++;
		if (noisy) apb_write(ADDR_SPARE, $urandom());
		apb_check_start();
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else begin
			if (stall_left > 0) stall_left--;
			else if (!calm && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
			result_bus.ready <= (stall_left == 0);
		end
	end

	always @(posedge clk) begin
		mnas_pkg::result_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (next_addr_q.size() == 0) begin
				$display("%0t: result beat with nothing expected, got %h", $time,
					result_bus.data);
				mismatches++;
			end else begin
				want = next_addr_q.pop_front();
				compare_field("next_index", 32'(want.next_index),
					32'(result_bus.data.next_index));
				compare_field("error", 32'(want.error), 32'(result_bus.data.error));
				compare_field("decoded", 32'(want.decoded), 32'(result_bus.data.decoded));
				compare_field("rd_index", 32'(want.rd_index), 32'(result_bus.data.rd_index));
				compare_field("rs1_index", 32'(want.rs1_index),
					32'(result_bus.data.rs1_index));
				compare_field("rs2_index", 32'(want.rs2_index),
					32'(result_bus.data.rs2_index));
				beats_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, STUCK_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		logic [PC_BITS-1:0] starts [PHASES];
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_bus.valid = 1'b0;
		item_bus.data = '0;
		calm = 1'b0;
		pc_model = '0;
		start_model = '0;
		foreach (entry_live[s]) entry_live[s] = 1'b0;
		starts = '{10'd1023, 10'd0, PC_BITS'($urandom()), 10'd512, PC_BITS'($urandom()),
			PC_BITS'($urandom())};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		build_directed();
		foreach (script[i]) begin
			maybe_gap();
			send_item(script[i].stim, script[i].typed, script[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			drain();
			set_start(starts[p], p == 1 || p == 4);
			calm = (p == PHASES - 1);
			repeat (PHASE_ITEMS) begin
				maybe_gap();
				send_item(random_item(), 1'b0, '0);
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (next_addr_q.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, next_addr_q.size());
			mismatches++;
		end
		$display("covered %0d items: %0d entry loads, %0d dispatch hits, %0d misses, %0d bad kinds",
			items_sent, loads_seen, dispatch_hits, dispatch_misses, bad_kinds);
		$display("%0d start index settings, %0d result beats checked, %0d mismatches",
			settings_used, beats_checked, mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
